FILE: hdl/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants of the stack allocator
// Field widths, result codes, controller states and register map.
// ----------------------------------------------------------------------------
package sal_pkg;

   // Field widths of the request, result and register port.
   localparam int SIZE_W  = 25;
   localparam int ADDR_W  = 24;
   localparam int TOTAL_W = 30;
   localparam int LIVE_W  = 6;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // Largest request size; bigger sizes are clipped to it.
   localparam logic [SIZE_W-1:0] SIZE_LIMIT = 25'h100_0000;

   // Register map and reset value of the capacity register.
   localparam logic CSR_IDX_CAPACITY = 1'b0;
   localparam logic [SIZE_W-1:0] CAPACITY_RESET = 25'h100_0000;

   // Request kinds.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Result codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_MISMATCH = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_READ
   } state_type;

   // One result item as held in the output register.
   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  offset;
      logic               used_fallback;
      logic [SIZE_W-1:0]  block_size;
      logic [TOTAL_W-1:0] allocation_total;
      logic [TOTAL_W-1:0] peak_allocation;
      logic [LIVE_W-1:0]  live_entries;
   } result_type;

endpackage

FILE: hdl/sal_req_if.sv
// ----------------------------------------------------------------------------
// sal_req_if: request channel of the stack allocator
// Valid/ready channel carrying one allocate or free item.
// ----------------------------------------------------------------------------
interface sal_req_if;
   import sal_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [SIZE_W-1:0] size;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output kind, output size, output address, input ready);
   modport sink   (input valid, input kind, input size, input address, output ready);

endinterface

FILE: hdl/sal_rsp_if.sv
// ----------------------------------------------------------------------------
// sal_rsp_if: result channel of the stack allocator
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface sal_rsp_if;
   import sal_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   logic [ADDR_W-1:0]  offset;
   logic               used_fallback;
   logic [SIZE_W-1:0]  block_size;
   logic [TOTAL_W-1:0] allocation_total;
   logic [TOTAL_W-1:0] peak_allocation;
   logic [LIVE_W-1:0]  live_entries;

   modport source (output valid, output status, output offset, output used_fallback,
                   output block_size, output allocation_total, output peak_allocation,
                   output live_entries, input ready);
   modport sink   (input valid, input status, input offset, input used_fallback,
                   input block_size, input allocation_total, input peak_allocation,
                   input live_entries, output ready);

endinterface

FILE: hdl/sal_ram.sv
// ----------------------------------------------------------------------------
// sal_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset of the contents.
// ----------------------------------------------------------------------------
module sal_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/stack_allocator_with_fallback.sv
// ----------------------------------------------------------------------------
// stack_allocator_with_fallback: LIFO allocator over a byte store
// Requests arrive on req_chan (allocate or free the top block) and each one
// yields exactly one item on rsp_chan. The capacity register is written over
// the csr_ APB-style port at byte address 0; the user must write it only while
// the block is idle, which the block does not enforce. An allocate completes
// on acceptance when ALIGN_BYTES is a power of two; otherwise the size is
// rounded by a multiply with the reciprocal of the alignment. A free waits
// in the read state for the registered read of the entry memory that holds
// the size and fallback mark of every live block. The result sits in an
// output register; a new item is accepted in the cycle that register is
// taken, so allocates can follow one per cycle when ALIGN_BYTES is a power of
// two. On a receiver stall the result holds and no new item is accepted.
// Reset clears the entry count, top, totals and peak and sets the capacity
// to 16 MiB; the entry memory is not cleared, only live entries are read.
// ----------------------------------------------------------------------------
module stack_allocator_with_fallback #(
   parameter int MAX_ENTRIES = 32,
   parameter int ALIGN_BYTES = 32,
   parameter int STORE_BYTES = 16777216
) (
   input  logic                        clock,
   input  logic                        reset,
   sal_req_if.sink                     req_chan,
   sal_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sal_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sal_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sal_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import sal_pkg::*;

   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int ENTRY_W = SIZE_W + 1;
   localparam int ALIGN_LOG = $clog2(ALIGN_BYTES);
   localparam int RECIP_SH  = SIZE_W + ALIGN_LOG;
   localparam int PROD_W    = RECIP_SH + SIZE_W;
   localparam bit ALIGN_POW2 = (ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0;

   localparam logic [SIZE_W:0]    ALIGN_M1   = (SIZE_W + 1)'(ALIGN_BYTES - 1);
   localparam logic [SIZE_W:0]    ALIGN_MASK = ~ALIGN_M1;
   localparam logic [SIZE_W:0]    RECIP      = (SIZE_W + 1)'(
      ((64'd1 << RECIP_SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
   localparam logic [SIZE_W-1:0]  ALIGN_Q    = SIZE_W'(ALIGN_BYTES);
   localparam logic [CNT_W-1:0]   MAX_CNT    = CNT_W'(MAX_ENTRIES);
   localparam logic [30:0]        STORE_LIM  = 31'(STORE_BYTES);
   localparam logic [1:0]         STEP_FIRST = 2'd2;

   // Registers.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SIZE_W-1:0]  top_ff, top_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] peak_ff, peak_in;
   logic [SIZE_W-1:0]  capacity_ff, capacity_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         result_ff, result_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  quot_ff, quot_in;
   logic [SIZE_W-1:0]  rnd_ff, rnd_in;
   logic [1:0]         step_ff, step_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;

   // Handshake and decode.
   logic               accept;
   logic               is_alloc;
   logic               is_free;
   logic               full;
   logic               empty;
   logic               slot_free;
   logic               csr_write;
   logic               csr_hit;

   // Rounding.
   logic [SIZE_W-1:0]  size_clamped;
   logic [SIZE_W:0]    p2_sum;
   logic [SIZE_W-1:0]  p2_rsz;
   logic [PROD_W-1:0]  recip_prod;
   logic               last_step;
   logic [SIZE_W-1:0]  rsz;

   // Allocate outcome.
   logic               alloc_go;
   logic [SIZE_W-1:0]  cap_eff;
   logic [SIZE_W:0]    alloc_end;
   logic               alloc_fb;
   logic [TOTAL_W-1:0] alloc_total;
   logic [TOTAL_W-1:0] alloc_peak;

   // Free outcome.
   logic [ENTRY_W-1:0] rd_entry;
   logic [SIZE_W-1:0]  free_size;
   logic               free_fb;
   logic [SIZE_W-1:0]  free_top;
   logic [ADDR_W-1:0]  free_expect;
   logic               free_match;
   logic               free_go;

   // Memory port controls.
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;

   // Entry memory: size and fallback mark of each live block.
   sal_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (alloc_go),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_entry)
   );

   // Request decode and stack occupancy.
   assign accept    = req_chan.valid && req_chan.ready;
   assign is_alloc  = req_chan.kind == KIND_ALLOC;
   assign is_free   = req_chan.kind == KIND_FREE;
   assign full      = count_ff >= MAX_CNT;
   assign empty     = (count_ff == '0) || (count_ff > MAX_CNT);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Power-of-two rounding is a single add and mask.
   assign size_clamped = (req_chan.size > SIZE_LIMIT) ? SIZE_LIMIT : req_chan.size;
   assign p2_sum       = {1'b0, size_clamped} + ALIGN_M1;
   assign p2_rsz       = p2_sum[SIZE_W-1:0] & ALIGN_MASK[SIZE_W-1:0];

   // Other alignments: the quotient of the biased size comes from a multiply
   // with the scaled reciprocal, then a constant multiply gives the bytes.
   assign recip_prod = PROD_W'(size_ff) * PROD_W'(RECIP);
   assign last_step  = step_ff == '0;

   // The allocate completes in the accept cycle or after the last rounding step.
   assign alloc_go = ALIGN_POW2 ? (accept && is_alloc && !full)
                                : ((state_ff == ST_ROUND) && last_step);
   assign rsz      = ALIGN_POW2 ? p2_rsz : rnd_ff;

   // Fit check against the capacity clipped to the store size.
   assign cap_eff     = ({6'b0, capacity_ff} > STORE_LIM) ? STORE_LIM[SIZE_W-1:0]
                                                          : capacity_ff;
   assign alloc_end   = {1'b0, top_ff} + {1'b0, rsz};
   assign alloc_fb    = alloc_end > {1'b0, cap_eff};
   assign alloc_total = total_ff + TOTAL_W'(rsz);
   assign alloc_peak  = (alloc_total > peak_ff) ? alloc_total : peak_ff;

   // Free check against the top entry read from memory.
   assign free_size   = rd_entry[SIZE_W-1:0];
   assign free_fb     = rd_entry[SIZE_W];
   assign free_top    = top_ff - free_size;
   assign free_expect = free_fb ? '0 : free_top[ADDR_W-1:0];
   assign free_match  = addr_ff == free_expect;
   assign free_go     = (state_ff == ST_READ) && free_match;

   // Memory addresses: push at the count, pop reads the entry below it.
   assign ram_wr_addr = count_ff[IDX_W-1:0];
   assign ram_wr_data = {alloc_fb, rsz};
   assign ram_rd_addr = IDX_W'(count_ff - CNT_W'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_alloc && !full && !ALIGN_POW2) begin
                  state_in = ST_ROUND;
               end else if (is_free && !empty) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_ROUND: begin
            if (last_step) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_chan.ready = 1'b0;
      ram_rd_en      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = slot_free && !reset;
            ram_rd_en      = req_chan.valid && slot_free && is_free && !empty;
         end
         ST_ROUND: begin
            req_chan.ready = 1'b0;
         end
         ST_READ: begin
            req_chan.ready = 1'b0;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   // Allocator state and result register.
   always_comb begin
      count_in     = count_ff;
      top_in       = top_ff;
      total_in     = total_ff;
      peak_in      = peak_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      result_in    = result_ff;

      if (alloc_go) begin
         count_in = count_ff + CNT_W'(1);
         total_in = alloc_total;
         peak_in  = alloc_peak;
         if (!alloc_fb) begin
            top_in = alloc_end[SIZE_W-1:0];
         end
         rsp_valid_in               = 1'b1;
         result_in.status           = STATUS_OK;
         result_in.offset           = alloc_fb ? '0 : top_ff[ADDR_W-1:0];
         result_in.used_fallback    = alloc_fb;
         result_in.block_size       = rsz;
         result_in.allocation_total = alloc_total;
         result_in.peak_allocation  = alloc_peak;
         result_in.live_entries     = LIVE_W'(count_ff + CNT_W'(1));
      end else if (free_go) begin
         count_in = count_ff - CNT_W'(1);
         total_in = total_ff - TOTAL_W'(free_size);
         if (!free_fb) begin
            top_in = free_top;
         end
         rsp_valid_in               = 1'b1;
         result_in.status           = STATUS_OK;
         result_in.offset           = '0;
         result_in.used_fallback    = free_fb;
         result_in.block_size       = free_size;
         result_in.allocation_total = total_ff - TOTAL_W'(free_size);
         result_in.peak_allocation  = peak_ff;
         result_in.live_entries     = LIVE_W'(count_ff - CNT_W'(1));
      end else if ((state_ff == ST_READ) || (accept && is_alloc && full)
                   || (accept && is_free && empty)) begin
         // Refused request: state stays, only the code differs.
         rsp_valid_in               = 1'b1;
         result_in.status           = (state_ff == ST_READ) ? STATUS_MISMATCH
                                    : (is_alloc ? STATUS_FULL : STATUS_EMPTY);
         result_in.offset           = '0;
         result_in.used_fallback    = 1'b0;
         result_in.block_size       = '0;
         result_in.allocation_total = total_ff;
         result_in.peak_allocation  = peak_ff;
         result_in.live_entries     = LIVE_W'(count_ff);
      end
   end

   // Request capture and the rounding steps.
   always_comb begin
      size_in = size_ff;
      addr_in = addr_ff;
      quot_in = quot_ff;
      rnd_in  = rnd_ff;
      step_in = step_ff;
      if (accept) begin
         size_in = p2_sum[SIZE_W-1:0];
         addr_in = req_chan.address;
         step_in = STEP_FIRST;
      end else if (state_ff == ST_ROUND) begin
         quot_in = recip_prod[RECIP_SH +: SIZE_W];
         rnd_in  = quot_ff * ALIGN_Q;
         step_in = step_ff - 2'd1;
      end
   end

   // Configuration port: one register, always ready.
   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit     = csr_paddr[2] == CSR_IDX_CAPACITY;
   assign capacity_in = (csr_write && csr_hit) ? csr_pwdata[SIZE_W-1:0] : capacity_ff;
   assign csr_prdata  = csr_hit ? CSR_DW'(capacity_ff) : '0;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      result_ff <= result_in;
      size_ff   <= size_in;
      addr_ff   <= addr_in;
      quot_ff   <= quot_in;
      rnd_ff    <= rnd_in;
      step_ff   <= step_in;
   end

   // Result channel.
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = result_ff.status;
   assign rsp_chan.offset           = result_ff.offset;
   assign rsp_chan.used_fallback    = result_ff.used_fallback;
   assign rsp_chan.block_size       = result_ff.block_size;
   assign rsp_chan.allocation_total = result_ff.allocation_total;
   assign rsp_chan.peak_allocation  = result_ff.peak_allocation;
   assign rsp_chan.live_entries     = result_ff.live_entries;

   // The entry count never runs past the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count exceeds the stack depth");

   // A pending memory read always finds the output register empty.
   a_read_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("output register occupied during a free lookup");

   // A free of a nonempty stack goes to the memory lookup.
   a_free_lookup: assert property (@(posedge clock) disable iff (reset)
      (accept && is_free && !empty) |=> (state_ff == ST_READ))
      else $error("free did not start a memory lookup");

   // A push is never committed on a full stack.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      alloc_go |-> !full)
      else $error("allocate committed on a full stack");

   // A full status is reported only while the stack is full.
   a_full_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (result_ff.status == STATUS_FULL)) |-> (count_ff == MAX_CNT))
      else $error("full status with room on the stack");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LIFO stack allocator with fallback
// A driver feeds allocate and free items from a queue and a monitor takes the
// result items. Every accepted item runs through a predictor that tracks the
// entry stack, top, totals and peak, and each result is compared field by
// field. The capacity register is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb;
   import sal_pkg::*;

   localparam int MAX_ENTRIES   = 32;
   localparam int ALIGN_BYTES   = 32;
   localparam int STORE_BYTES   = 16777216;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PHASE_ITEMS   = 220;
   localparam logic [CSR_AW-1:0] CAPACITY_ADDR = CSR_AW'(4 * int'(CSR_IDX_CAPACITY));

   // How the driver fills in the address of a free item.
   typedef enum logic [1:0] {
      ADDR_GIVEN,
      ADDR_TOP,
      ADDR_TOP_FLIPPED
   } addr_mode_type;

   typedef struct {
      logic              kind;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] address;
      addr_mode_type     mode;
   } pending_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sal_req_if req_chan ();
   sal_rsp_if rsp_chan ();

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Predicted allocator state.
   logic [SIZE_W-1:0]  stack_sizes [MAX_ENTRIES];
   logic               stack_fallback [MAX_ENTRIES];
   int                 stack_depth = 0;
   logic [SIZE_W-1:0]  stack_top = '0;
   logic [TOTAL_W-1:0] bytes_in_use = '0;
   logic [TOTAL_W-1:0] bytes_peak = '0;
   logic [SIZE_W-1:0]  capacity_setting = CAPACITY_RESET;

   pending_item_type pending [$];
   result_type       results_due [$];
   pending_item_type next_item;
   result_type       want;

   // Stimulus shaping and bookkeeping.
   bit no_gaps = 1'b0;
   int walk_depth = 0;
   int walk_target = 0;
   int error_count = 0;
   int quiet_cycles = 0;
   int items_accepted = 0;
   int settings_used = 1;
   int status_seen [4] = '{0, 0, 0, 0};
   int fallback_seen = 0;

   stack_allocator_with_fallback #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .ALIGN_BYTES(ALIGN_BYTES),
      .STORE_BYTES(STORE_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Address that a free of the current top entry must carry.
   function automatic logic [ADDR_W-1:0] top_block_address();
      if (stack_depth == 0 || stack_fallback[stack_depth-1]) begin
         return '0;
      end
      return ADDR_W'(stack_top - stack_sizes[stack_depth-1]);
   endfunction

   // Apply one request to the predicted state and return its result.
   function automatic result_type predict_result(input logic kind,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [ADDR_W-1:0] address);
      result_type        r;
      int                eff_cap;
      int                req_bytes;
      logic [SIZE_W-1:0] rounded;
      logic              fits;
      int                t;
      r = '0;
      r.status = STATUS_OK;
      if (kind == KIND_ALLOC) begin
         if (stack_depth >= MAX_ENTRIES) begin
            r.status = STATUS_FULL;
         end else begin
            eff_cap = (int'(capacity_setting) > STORE_BYTES) ? STORE_BYTES
                                                             : int'(capacity_setting);
            req_bytes = (size > SIZE_LIMIT) ? int'(SIZE_LIMIT) : int'(size);
            rounded = SIZE_W'((req_bytes + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES);
            fits = (int'(stack_top) + int'(rounded)) <= eff_cap;
            if (fits) begin
               r.offset = ADDR_W'(stack_top);
               stack_top = SIZE_W'(stack_top + rounded);
            end
            bytes_in_use = TOTAL_W'(bytes_in_use + rounded);
            if (bytes_in_use > bytes_peak) begin
               bytes_peak = bytes_in_use;
            end
            stack_sizes[stack_depth] = rounded;
            stack_fallback[stack_depth] = !fits;
            stack_depth++;
            r.used_fallback = !fits;
            r.block_size = rounded;
         end
      end else begin
         if (stack_depth == 0) begin
            r.status = STATUS_EMPTY;
         end else if (address != top_block_address()) begin
            r.status = STATUS_MISMATCH;
         end else begin
            t = stack_depth - 1;
            if (!stack_fallback[t]) begin
               stack_top = SIZE_W'(stack_top - stack_sizes[t]);
            end
            bytes_in_use = TOTAL_W'(bytes_in_use - stack_sizes[t]);
            stack_depth = t;
            r.used_fallback = stack_fallback[t];
            r.block_size = stack_sizes[t];
         end
      end
      r.allocation_total = bytes_in_use;
      r.peak_allocation = bytes_peak;
      r.live_entries = LIVE_W'(stack_depth);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] expected_value,
                                       input logic [31:0] actual_value);
      if (expected_value !== actual_value) begin
         $display("%0t: %s differs, expected 0x%0h, actual 0x%0h",
                  $time, name, expected_value, actual_value);
         error_count++;
      end
   endfunction

   // Driver: presents queued items, resolving free addresses against the
   // predicted stack once all earlier items have been accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            results_due.push_back(predict_result(req_chan.kind, req_chan.size,
                                                 req_chan.address));
            items_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending.size() != 0 && (no_gaps || $urandom_range(99) >= 8)) begin
               next_item = pending.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.kind <= next_item.kind;
               req_chan.size <= next_item.size;
               case (next_item.mode)
                  ADDR_TOP: begin
                     req_chan.address <= top_block_address();
                  end
                  ADDR_TOP_FLIPPED: begin
                     req_chan.address <= top_block_address() ^ next_item.address;
                  end
                  default: begin
                     req_chan.address <= next_item.address;
                  end
               endcase
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result item against the oldest prediction and
   // watches for a stalled handshake.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual status 0x%0h",
                        $time, rsp_chan.status);
               error_count++;
            end else begin
               want = results_due.pop_front();
               check_field("status", want.status, rsp_chan.status);
               check_field("offset", want.offset, rsp_chan.offset);
               check_field("used_fallback", want.used_fallback, rsp_chan.used_fallback);
               check_field("block_size", want.block_size, rsp_chan.block_size);
               check_field("allocation_total", want.allocation_total,
                           rsp_chan.allocation_total);
               check_field("peak_allocation", want.peak_allocation,
                           rsp_chan.peak_allocation);
               check_field("live_entries", want.live_entries, rsp_chan.live_entries);
               status_seen[want.status]++;
               if (want.status == STATUS_OK && want.used_fallback) begin
                  fallback_seen++;
               end
            end
         end
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         rsp_chan.ready <= no_gaps || ($urandom_range(99) >= 8);
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item accepted in %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic add_item(input logic kind, input logic [SIZE_W-1:0] size,
                           input logic [ADDR_W-1:0] address, input addr_mode_type mode);
      pending_item_type it;
      it.kind = kind;
      it.size = size;
      it.address = address;
      it.mode = mode;
      pending.push_back(it);
   endtask

   // Waits until every queued item is accepted and every result has arrived,
   // then lets the block settle. The check runs on the falling edge, where
   // the driver's and monitor's updates of the rising edge have landed.
   task automatic wait_for_drain();
      while (pending.size() != 0 || req_chan.valid || results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle.
   task automatic write_capacity(input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CAPACITY_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      capacity_setting = value[SIZE_W-1:0];
      settings_used++;
   endtask

   // Random items as a walk of the stack depth toward changing targets, so
   // the stack fills past full and drains past empty, with some noise.
   task automatic queue_random_items(input int count);
      int                pick;
      int                size_class;
      logic [SIZE_W-1:0] sz;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (walk_depth == walk_target) begin
            walk_target = $urandom_range(0, MAX_ENTRIES + 4);
         end
         if (pick < 4) begin
            add_item(KIND_ALLOC, SIZE_W'($urandom), ADDR_W'($urandom), ADDR_GIVEN);
            if (walk_depth < MAX_ENTRIES) begin
               walk_depth++;
            end
         end else if (pick < 8) begin
            add_item(KIND_FREE, SIZE_W'($urandom), ADDR_W'($urandom), ADDR_GIVEN);
         end else if (walk_depth < walk_target) begin
            size_class = $urandom_range(99);
            if (size_class < 60) begin
               sz = SIZE_W'($urandom_range(0, 256));
            end else if (size_class < 85) begin
               sz = SIZE_W'($urandom_range(0, 65536));
            end else if (size_class < 95) begin
               sz = SIZE_W'($urandom_range(0, 1 << 22));
            end else begin
               sz = SIZE_W'($urandom);
            end
            add_item(KIND_ALLOC, sz, ADDR_W'($urandom), ADDR_GIVEN);
            if (walk_depth < MAX_ENTRIES) begin
               walk_depth++;
            end else begin
               walk_target--;
            end
         end else if (pick < 16) begin
            add_item(KIND_FREE, SIZE_W'($urandom), ADDR_W'($urandom_range(1, 24'hFF_FFFF)),
                     ADDR_TOP_FLIPPED);
         end else begin
            add_item(KIND_FREE, SIZE_W'($urandom), '0, ADDR_TOP);
            if (walk_depth > 0) begin
               walk_depth--;
            end
         end
      end
   endtask

   initial begin
      logic [CSR_DW-1:0] phase_capacity [7];
      phase_capacity = '{32'hFFFF_FFFF, 32'd0, 32'd4096, 32'h0100_0000,
                         CSR_DW'($urandom_range(0, 32'h1FF_FFFF)), 32'd65536,
                         CSR_DW'(CAPACITY_RESET)};
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_ALLOC;
      req_chan.size = '0;
      req_chan.address = '0;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset capacity: free on empty, zero size,
      // rounding edges, wrong addresses, oversized fallback, and filling the
      // store exactly so the top reaches the full 16 MiB.
      add_item(KIND_FREE, '0, 24'hFF_FFFF, ADDR_GIVEN);
      add_item(KIND_ALLOC, 25'd0, '0, ADDR_GIVEN);
      add_item(KIND_ALLOC, 25'd1, '0, ADDR_GIVEN);
      add_item(KIND_ALLOC, 25'd31, '0, ADDR_GIVEN);
      add_item(KIND_ALLOC, 25'd32, '0, ADDR_GIVEN);
      add_item(KIND_ALLOC, 25'd33, '0, ADDR_GIVEN);
      add_item(KIND_FREE, '0, 24'd1, ADDR_TOP_FLIPPED);
      add_item(KIND_FREE, '0, '0, ADDR_TOP);
      add_item(KIND_ALLOC, 25'h1FF_FFFF, 24'hFF_FFFF, ADDR_GIVEN);
      add_item(KIND_FREE, 25'h1FF_FFFF, 24'h80_0000, ADDR_GIVEN);
      add_item(KIND_FREE, '0, '0, ADDR_TOP);
      repeat (4) add_item(KIND_FREE, '0, '0, ADDR_TOP);
      add_item(KIND_FREE, '0, '0, ADDR_TOP);
      add_item(KIND_ALLOC, 25'd16777184, '0, ADDR_GIVEN);
      add_item(KIND_ALLOC, 25'd32, '0, ADDR_GIVEN);
      add_item(KIND_ALLOC, 25'd0, '0, ADDR_GIVEN);
      add_item(KIND_ALLOC, 25'd1, '0, ADDR_GIVEN);
      repeat (4) add_item(KIND_FREE, '0, '0, ADDR_TOP);
      wait_for_drain();

      // Random phases, each under its own capacity; the stack is carried over
      // so a lowered capacity can sit below the current top.
      for (int p = 0; p < 7; p++) begin
         write_capacity(phase_capacity[p]);
         no_gaps = (p == 2);
         queue_random_items(PHASE_ITEMS / 2);
         wait_for_drain();
         queue_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
         wait_for_drain();
      end
      no_gaps = 1'b0;

      if (results_due.size() != 0) begin
         $display("%0t: predictions left over, expected 0, actual %0d",
                  $time, results_due.size());
         error_count++;
      end
      $display("Ran %0d requests under %0d capacity settings, with %0d mismatches.",
               items_accepted, settings_used, error_count);
      $display("Outcomes: %0d ok (%0d fallback), %0d full, %0d empty free, %0d bad address.",
               status_seen[STATUS_OK], fallback_seen, status_seen[STATUS_FULL],
               status_seen[STATUS_EMPTY], status_seen[STATUS_MISMATCH]);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
